/* design/kprd_pkg.sv */
// ----------------------------------------------------------------------------
// kprd_pkg: shared types and constants for the keypad repeat block
// Item structs, controller states, command and status groups, button map.
// ----------------------------------------------------------------------------
`default_nettype none

package kprd_pkg;

	localparam int BTN_COUNT   = 20;
	localparam int INTERVAL_W  = 8;
	localparam int DELAY_W     = 16;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	localparam int BTN_DOWN  = 0;
	localparam int BTN_LEFT  = 1;
	localparam int BTN_RIGHT = 2;
	localparam int BTN_UP    = 3;
	localparam int BTN_A     = 4;
	localparam int BTN_B     = 5;
	localparam int BTN_C     = 6;
	localparam int BTN_X     = 7;
	localparam int BTN_Y     = 8;
	localparam int BTN_Z     = 9;
	localparam int BTN_L     = 10;
	localparam int BTN_R     = 11;
	localparam int BTN_SHIFT = 12;
	localparam int BTN_F5    = 15;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DELAY    = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_INTERVAL = 4'd1;

	localparam logic [DELAY_W-1:0]    DELAY_RESET    = 16'd24;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd6;

	localparam logic [3:0] DIR_NONE       = 4'd0;
	localparam logic [3:0] DIR_DOWN_LEFT  = 4'd1;
	localparam logic [3:0] DIR_DOWN       = 4'd2;
	localparam logic [3:0] DIR_DOWN_RIGHT = 4'd3;
	localparam logic [3:0] DIR_LEFT       = 4'd4;
	localparam logic [3:0] DIR_CENTER     = 4'd5;
	localparam logic [3:0] DIR_RIGHT      = 4'd6;
	localparam logic [3:0] DIR_UP_LEFT    = 4'd7;
	localparam logic [3:0] DIR_UP         = 4'd8;
	localparam logic [3:0] DIR_UP_RIGHT   = 4'd9;
	localparam logic [3:0] VERT_STEP      = 4'd3;
	localparam logic [3:0] HORIZ_STEP     = 4'd1;

	typedef struct packed {
		logic [14:0] mapped_keys;
		logic [3:0]  arrow_keys;
		logic [2:0]  modifier_keys;
		logic [4:0]  function_keys;
	} kprd_in_t;

	typedef struct packed {
		logic [BTN_COUNT-1:0] held_mask;
		logic [BTN_COUNT-1:0] trigger_mask;
		logic [BTN_COUNT-1:0] repeat_mask;
		logic [3:0]           direction_eight;
		logic [3:0]           direction_four;
	} kprd_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MOD,
		ST_EMIT
	} kprd_state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic step;
		logic emit;
	} kprd_cmd_t;

	typedef struct packed {
		logic last_bit;
		logic out_free;
	} kprd_status_t;

	function automatic logic [BTN_COUNT-1:0] map_keys(input kprd_in_t k);
		logic [BTN_COUNT-1:0] h;
		h = '0;
		h[BTN_C] = k.mapped_keys[0] | k.mapped_keys[1] | k.mapped_keys[5];
		h[BTN_B] = k.mapped_keys[2] | k.mapped_keys[3] | k.mapped_keys[6];
		h[BTN_A] = k.mapped_keys[4];
		h[BTN_X] = k.mapped_keys[10];
		h[BTN_Y] = k.mapped_keys[11];
		h[BTN_Z] = k.mapped_keys[12];
		h[BTN_L] = k.mapped_keys[13];
		h[BTN_R] = k.mapped_keys[14];
		h[BTN_UP:BTN_DOWN] = k.arrow_keys;
		h[BTN_SHIFT+2:BTN_SHIFT] = k.modifier_keys;
		h[BTN_F5+4:BTN_F5] = k.function_keys;
		return h;
	endfunction

endpackage

`default_nettype wire

/* design/kprd_ctrl.sv */
// ----------------------------------------------------------------------------
// kprd_ctrl: frame sequencer
// Accepts a frame, updates counters, walks remainder bits, emits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module kprd_ctrl
	import kprd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  kprd_status_t status,
	output kprd_cmd_t    cmd
);

	kprd_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_UPDATE;
			end
			ST_UPDATE: state_nxt = ST_MOD;
			ST_MOD: begin
				if (status.last_bit) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_UPDATE: cmd.update = 1'b1;
			ST_MOD:    cmd.step   = 1'b1;
			ST_EMIT:   cmd.emit   = status.out_free;
			default:   cmd        = '0;
		endcase
	end

endmodule

`default_nettype wire

/* design/kprd_dp.sv */
// ----------------------------------------------------------------------------
// kprd_dp: hold counters, bit-serial remainder lanes and result register
// One remainder lane per button computes count mod repeat_interval.
// ----------------------------------------------------------------------------
`default_nettype none

module kprd_dp
	import kprd_pkg::*;
#(
	parameter int NUM_BUTTONS = 20,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  kprd_in_t                    in_item,
	input  kprd_cmd_t                   cmd,
	output kprd_status_t                status,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output kprd_out_t                   out_item
);

	localparam int BIT_W = $clog2(COUNT_WIDTH);
	localparam int CMP_W = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;

	logic [BTN_COUNT-1:0]   held_q;
	logic [NUM_BUTTONS-1:0] held_ext;
	logic [COUNT_WIDTH-1:0] count_q [NUM_BUTTONS];
	logic [INTERVAL_W-1:0]  rem_q   [NUM_BUTTONS];
	logic [INTERVAL_W-1:0]  rem_nxt [NUM_BUTTONS];
	logic [BIT_W-1:0]       bit_q;
	logic [DELAY_W-1:0]     delay_q;
	logic [INTERVAL_W-1:0]  interval_q;
	logic                   out_valid_q;
	kprd_out_t              out_q;
	logic [BTN_COUNT-1:0]   trig;
	logic [BTN_COUNT-1:0]   rep;
	logic [3:0]             d8;
	logic [3:0]             d4;

	assign held_ext = NUM_BUTTONS'(held_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DELAY_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_DELAY:    delay_q    <= cfg_data;
				CFG_IDX_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) held_q <= map_keys(in_item);
	end

	// saturating hold counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) count_q[i] <= '0;
		end else if (cmd.update) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (!held_ext[i]) begin
					count_q[i] <= '0;
				end else if (count_q[i] != '1) begin
					count_q[i] <= count_q[i] + COUNT_WIDTH'(1);
				end
			end
		end
	end

	// restoring remainder, msb first
	always_comb begin
		logic [INTERVAL_W:0] t;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			t = {rem_q[i], count_q[i][bit_q]};
			if (t >= {1'b0, interval_q}) t = t - {1'b0, interval_q};
			rem_nxt[i] = t[INTERVAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < NUM_BUTTONS; i++) rem_q[i] <= '0;
			bit_q <= BIT_W'(COUNT_WIDTH - 1);
		end else if (cmd.step) begin
			for (int i = 0; i < NUM_BUTTONS; i++) rem_q[i] <= rem_nxt[i];
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	assign status.last_bit = (bit_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	always_comb begin
		trig = '0;
		rep  = '0;
		for (int i = 0; i < BTN_COUNT; i++) begin
			trig[i] = (count_q[i] == COUNT_WIDTH'(1));
			rep[i]  = trig[i] ||
			          ((interval_q != '0) && (count_q[i] != '0) &&
			           (CMP_W'(count_q[i]) >= CMP_W'(delay_q)) && (rem_q[i] == '0));
		end
	end

	// eight-way and four-way direction
	always_comb begin
		d8 = DIR_CENTER;
		if (held_q[BTN_DOWN])  d8 = d8 - VERT_STEP;
		if (held_q[BTN_LEFT])  d8 = d8 - HORIZ_STEP;
		if (held_q[BTN_RIGHT]) d8 = d8 + HORIZ_STEP;
		if (held_q[BTN_UP])    d8 = d8 + VERT_STEP;
		if (d8 == DIR_CENTER)  d8 = DIR_NONE;
		case (d8)
			DIR_DOWN_LEFT:
				d4 = (count_q[BTN_DOWN] > count_q[BTN_LEFT]) ? DIR_DOWN : DIR_LEFT;
			DIR_DOWN_RIGHT:
				d4 = (count_q[BTN_DOWN] > count_q[BTN_RIGHT]) ? DIR_DOWN : DIR_RIGHT;
			DIR_UP_LEFT:
				d4 = (count_q[BTN_UP] > count_q[BTN_LEFT]) ? DIR_UP : DIR_LEFT;
			DIR_UP_RIGHT:
				d4 = (count_q[BTN_UP] > count_q[BTN_RIGHT]) ? DIR_UP : DIR_RIGHT;
			default: d4 = d8;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.held_mask       <= held_q;
			out_q.trigger_mask    <= trig;
			out_q.repeat_mask     <= rep;
			out_q.direction_eight <= d8;
			out_q.direction_four  <= d4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

/* design/keypad_repeat_and_direction.sv */
// ----------------------------------------------------------------------------
// keypad_repeat_and_direction: keypad auto-repeat and direction controller
// Maps raw key bits to twenty buttons, tracks hold counts, emits masks.
// ----------------------------------------------------------------------------
// Each accepted item is one frame of key bits and yields one result item.
// A frame goes from acceptance to the result register in order: capture,
// an update of all hold counters, a shift of the counts one bit per cycle
// through the per-button remainder lanes that find count mod repeat_interval,
// and a load of the result once the output register is free. The next
// frame is taken as soon as the sequencer is back in idle, while a result
// may still wait in the output register. Counters clear at reset; no
// clearing pass. Configuration writes are always ready.
`default_nettype none

module keypad_repeat_and_direction
	import kprd_pkg::*;
#(
	parameter int NUM_BUTTONS = 20,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  kprd_in_t                    in_item,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output kprd_out_t                   out_item,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	kprd_cmd_t    cmd;
	kprd_status_t status;

	assign cfg_ready = 1'b1;

	kprd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	kprd_dp #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

/* design/kprd_chk.sv */
// ----------------------------------------------------------------------------
// kprd_chk: port-level checks for the keypad repeat block
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module kprd_chk
	import kprd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input kprd_out_t out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// an item is worked on alone
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new item taken while busy");

	a_masks_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.trigger_mask & ~out_item.held_mask) == '0) &&
		              ((out_item.repeat_mask & ~out_item.held_mask) == '0))
		else $error("trigger or repeat on a released button");

	a_trig_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.trigger_mask & ~out_item.repeat_mask) == '0))
		else $error("triggered button missing from repeat mask");

	a_dir_agree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.direction_eight == DIR_NONE) ==
		               (out_item.direction_four == DIR_NONE)))
		else $error("direction outputs disagree on no direction");

endmodule

bind keypad_repeat_and_direction kprd_chk u_kprd_chk (.*);

`default_nettype wire

/* verif/keypad_repeat_and_direction_test.sv */
// ----------------------------------------------------------------------------
// keypad_repeat_and_direction_test: self-checking bench for the keypad block
// Drives key frames with random gaps and output stalls and sweeps the repeat
// delay and interval registers, including their extremes. A scoreboard class
// keeps its own per-button hold counters, predicts the masks and both
// direction codes for each accepted frame, and checks every result item in
// order. One long hold runs well past a large repeat delay.
// ----------------------------------------------------------------------------
module keypad_repeat_and_direction_test
	import kprd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_W          = 16;
	localparam int LONG_HOLD_FRAMES = 280;
	localparam int NO_BUTTON        = -1;
	localparam int FRAME_CYCLES     = COUNT_W + 3;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int STALL_LIMIT      = 2000;
	localparam int IDLE_PCT         = 21;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LAST  = 4'd15;

	class frame_scoreboard;
		logic [COUNT_W-1:0]    counts [BTN_COUNT];
		logic [DELAY_W-1:0]    delay;
		logic [INTERVAL_W-1:0] interval;
		kprd_out_t             expected_frames [$];
		int                    errors;

		function new();
			foreach (counts[b])
				counts[b] = '0;
			delay = DELAY_RESET;
			interval = INTERVAL_RESET;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_IDX_DELAY) begin
				delay = data[DELAY_W-1:0];
			end else if (idx == CFG_IDX_INTERVAL) begin
				interval = data[INTERVAL_W-1:0];
			end
		endfunction

		function int button_of_key(int key);
			case (key)
				0, 1, 5: return BTN_C;
				2, 3, 6: return BTN_B;
				4:       return BTN_A;
				10:      return BTN_X;
				11:      return BTN_Y;
				12:      return BTN_Z;
				13:      return BTN_L;
				14:      return BTN_R;
				default: return NO_BUTTON;
			endcase
		endfunction

		function kprd_out_t predict_frame(kprd_in_t f);
			kprd_out_t            r;
			logic [BTN_COUNT-1:0] held;
			int                   btn;
			int                   dir8;
			int                   dir4;
			held = '0;
			for (int k = 0; k < $bits(f.mapped_keys); k++) begin
				btn = button_of_key(k);
				if (f.mapped_keys[k] && btn != NO_BUTTON)
					held[btn] = 1'b1;
			end
			for (int i = 0; i < $bits(f.arrow_keys); i++)
				held[BTN_DOWN + i] = f.arrow_keys[i];
			for (int i = 0; i < $bits(f.modifier_keys); i++)
				held[BTN_SHIFT + i] = f.modifier_keys[i];
			for (int i = 0; i < $bits(f.function_keys); i++)
				held[BTN_F5 + i] = f.function_keys[i];
			r = '0;
			r.held_mask = held;
			for (int b = 0; b < BTN_COUNT; b++) begin
				if (!held[b]) begin
					counts[b] = '0;
				end else if (counts[b] != '1) begin
					counts[b] = counts[b] + 1'b1;
				end
				if (counts[b] == 1) begin
					r.trigger_mask[b] = 1'b1;
					r.repeat_mask[b] = 1'b1;
				end else if (counts[b] != 0 && interval != 0 && counts[b] >= delay
						&& counts[b] % interval == 0) begin
					r.repeat_mask[b] = 1'b1;
				end
			end
			// opposite arrows cancel
			dir8 = DIR_CENTER;
			if (f.arrow_keys[BTN_DOWN])
				dir8 = dir8 - VERT_STEP;
			if (f.arrow_keys[BTN_LEFT])
				dir8 = dir8 - HORIZ_STEP;
			if (f.arrow_keys[BTN_RIGHT])
				dir8 = dir8 + HORIZ_STEP;
			if (f.arrow_keys[BTN_UP])
				dir8 = dir8 + VERT_STEP;
			if (dir8 == DIR_CENTER)
				dir8 = DIR_NONE;
			// diagonal goes vertical only on a strictly longer vertical hold
			dir4 = dir8;
			case (dir8)
				DIR_DOWN_LEFT:  dir4 = counts[BTN_DOWN] > counts[BTN_LEFT] ? DIR_DOWN : DIR_LEFT;
				DIR_DOWN_RIGHT: dir4 = counts[BTN_DOWN] > counts[BTN_RIGHT] ? DIR_DOWN : DIR_RIGHT;
				DIR_UP_LEFT:    dir4 = counts[BTN_UP] > counts[BTN_LEFT] ? DIR_UP : DIR_LEFT;
				DIR_UP_RIGHT:   dir4 = counts[BTN_UP] > counts[BTN_RIGHT] ? DIR_UP : DIR_RIGHT;
				default: ;
			endcase
			r.direction_eight = 4'(dir8);
			r.direction_four = 4'(dir4);
			return r;
		endfunction

		function void note_frame(kprd_in_t f);
			expected_frames.push_back(predict_frame(f));
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void compare_field(string label, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				if (errors < 10)
					$display("%0t: %s expected %h got %h", $time, label, want, seen);
				errors++;
			end
		endfunction

		function void check_result(kprd_out_t got);
			kprd_out_t want;
			if (expected_frames.size() == 0) begin
				if (errors < 10)
					$display("%0t: result item %h with nothing pending", $time, got);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				compare_field("held_mask", want.held_mask, got.held_mask);
				compare_field("trigger_mask", want.trigger_mask, got.trigger_mask);
				compare_field("repeat_mask", want.repeat_mask, got.repeat_mask);
				compare_field("direction_eight", want.direction_eight, got.direction_eight);
				compare_field("direction_four", want.direction_four, got.direction_four);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	kprd_in_t               in_item;
	logic                   out_valid;
	logic                   out_stall;
	kprd_out_t              out_item;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	frame_scoreboard sb = new();
	bit              calm = 1'b0;
	bit              hold_off_req = 1'b0;
	int              idle_cycles = 0;

	keypad_repeat_and_direction #(
		.NUM_BUTTONS(BTN_COUNT),
		.COUNT_WIDTH(COUNT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall = 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_stall = !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(out_item);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("keypad_repeat_and_direction_test: errors");
			$finish;
		end
	end

	function automatic kprd_in_t frame_of(logic [14:0] keys, logic [3:0] arrows,
			logic [2:0] mods, logic [4:0] fkeys);
		kprd_in_t f;
		f.mapped_keys = keys;
		f.arrow_keys = arrows;
		f.modifier_keys = mods;
		f.function_keys = fkeys;
		return f;
	endfunction

	function automatic kprd_in_t sparse_frame();
		return kprd_in_t'($urandom & $urandom);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_frame(kprd_in_t f);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_item = f;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_frame(f);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] delay, logic [CFG_DATA_W-1:0] interval);
		wait_drained();
		write_reg(CFG_IDX_DELAY, delay);
		write_reg(CFG_IDX_INTERVAL, interval);
	endtask

	// mostly steady holds with flickering extras, some pure noise frames
	task automatic run_phase(logic [CFG_DATA_W-1:0] delay, logic [CFG_DATA_W-1:0] interval,
			int frames, bit long_hold);
		kprd_in_t base;
		kprd_in_t flicker;
		int       sent;
		int       run_len;
		set_config(delay, interval);
		sent = 0;
		if (long_hold) begin
			base = sparse_frame();
			base.function_keys[0] = 1'b1;
			repeat (LONG_HOLD_FRAMES) offer_frame(base);
			sent = LONG_HOLD_FRAMES;
		end
		while (sent < frames) begin
			if ($urandom_range(99) < 80) begin
				base = sparse_frame();
				flicker = sparse_frame() & sparse_frame();
				run_len = $urandom_range(1, 40);
				repeat (run_len) offer_frame(base | (kprd_in_t'($urandom) & flicker));
				sent += run_len;
			end else begin
				run_len = $urandom_range(1, 5);
				repeat (run_len) offer_frame(kprd_in_t'($urandom));
				sent += run_len;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IDX_DELAY;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		offer_frame(frame_of(15'h0000, 4'h0, 3'h0, 5'h00));
		offer_frame(frame_of(15'h7fff, 4'hf, 3'h7, 5'h1f));
		offer_frame(frame_of(15'h7fff, 4'hf, 3'h7, 5'h1f));
		offer_frame(frame_of(15'h0000, 4'h0, 3'h0, 5'h00));
		// A as a mapped key, shift as a modifier, then both
		offer_frame(frame_of(15'h0010, 4'h0, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h0, 3'h1, 5'h00));
		offer_frame(frame_of(15'h0010, 4'h0, 3'h1, 5'h00));
		// unmapped keys alone, then mixed with mapped ones
		offer_frame(frame_of(15'h0380, 4'h0, 3'h0, 5'h00));
		offer_frame(frame_of(15'h5555, 4'h0, 3'h0, 5'h00));
		offer_frame(frame_of(15'h2aaa, 4'h0, 3'h0, 5'h00));
		// diagonals against hold lengths
		offer_frame(frame_of(15'h0000, 4'h1, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h1, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h3, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'hc, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h8, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'ha, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h4, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h5, 3'h0, 5'h00));
		// opposite arrows, then function and modifier keys
		offer_frame(frame_of(15'h0000, 4'h9, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h6, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'hb, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'he, 3'h0, 5'h00));
		offer_frame(frame_of(15'h0000, 4'h0, 3'h0, 5'h1f));
		offer_frame(frame_of(15'h0000, 4'h0, 3'h6, 5'h0a));

		// zero delay, then zero interval
		set_config(16'd0, 16'd1);
		repeat (8) offer_frame(frame_of(15'h4000, 4'h0, 3'h0, 5'h00));
		set_config(16'd0, 16'd0);
		repeat (8) offer_frame(frame_of(15'h4000, 4'h0, 3'h0, 5'h00));
		// writes to unused indexes change nothing
		set_config(16'd2, 16'd3);
		write_reg(CFG_IDX_SPARE, 16'h0001);
		write_reg(CFG_IDX_LAST, 16'hffff);
		repeat (10) offer_frame(frame_of(15'h0000, 4'h2, 3'h0, 5'h00));

		// drain first so the hold-off lands while frames are offered
		set_config(DELAY_RESET, INTERVAL_RESET);
		hold_off_req = 1'b1;
		run_phase(DELAY_RESET, INTERVAL_RESET, 250, 1'b0);
		run_phase(16'd255, 16'd255, 300, 1'b1);
		calm = 1'b1;
		run_phase(16'd1, 16'd1, 200, 1'b0);
		calm = 1'b0;
		run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 12)), 200, 1'b0);
		run_phase(16'hffff, 16'h00ff, 120, 1'b0);
		run_phase(16'($urandom), 16'($urandom), 160, 1'b0);
		set_config(16'd3, 16'ha502);
		hold_off_req = 1'b1;
		run_phase(16'd3, 16'ha502, 160, 1'b0);

		wait_drained();
		repeat (4 * FRAME_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("keypad_repeat_and_direction_test: clean");
		else
			$display("keypad_repeat_and_direction_test: errors");
		$finish;
	end

endmodule

/* keypad_repeat_and_direction.f */
design/kprd_pkg.sv
design/kprd_ctrl.sv
design/kprd_dp.sv
design/keypad_repeat_and_direction.sv
design/kprd_chk.sv
verif/keypad_repeat_and_direction_test.sv
